// ===== design/cplu_pkg.sv =====
// cplu_pkg: widths, latencies and word types for the closest points unit
// no dependencies; used by every file in the design folder
`default_nettype none

package cplu_pkg;

  localparam int COORD_W    = 32;   // Q16.16 coordinate
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int MPROD_W    = 2 * DOT_W;
  localparam int NUM_W      = MPROD_W + 1;   // den, na, nb
  localparam int MAG_W      = DIFF_W + NUM_W;
  localparam int QUOT_BITS  = COORD_W + 2;   // beyond this the point saturates
  localparam int QUOT_W     = QUOT_BITS + 1;

  localparam int MUL68_LAT  = 5;
  localparam int MULNA_LAT  = 3;
  localparam int DIV_LAT    = QUOT_BITS + 2;

  // delay lines in the top level, counted in register stages
  localparam int DL_UV      = 2 + MUL68_LAT + 1;
  localparam int DL_DEN     = MULNA_LAT;
  localparam int DL_DEG     = MULNA_LAT + DIV_LAT;
  localparam int DL_START   = DL_UV + MULNA_LAT + DIV_LAT;
  localparam int PIPE_DEPTH = DL_START + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_start_z;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] first_end_z;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_start_z;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
    logic signed [COORD_W-1:0] second_end_z;
  } pair_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_first_x;
    logic signed [COORD_W-1:0] near_first_y;
    logic signed [COORD_W-1:0] near_first_z;
    logic signed [COORD_W-1:0] near_second_x;
    logic signed [COORD_W-1:0] near_second_y;
    logic signed [COORD_W-1:0] near_second_z;
    logic                      degenerate;
  } near_word_t;

endpackage

`default_nettype wire

// ===== design/cplu_mul68.sv =====
// cplu_mul68: pipelined signed multiply of two dot products
// four half-width partial products; uses cplu_pkg
`default_nettype none

module cplu_mul68 (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [cplu_pkg::DOT_W-1:0]   a,
  input  wire logic signed [cplu_pkg::DOT_W-1:0]   b,
  output logic signed [cplu_pkg::MPROD_W-1:0]      p
);

  localparam int W = cplu_pkg::DOT_W;
  localparam int H = W / 2;
  localparam int PW = cplu_pkg::MPROD_W;

  logic [W-1:0]    aa, bb;
  logic            n1, n2, n3, n4;
  logic [2*H-1:0]  p00, p01, p10, p11;
  logic [2*H:0]    mid;
  logic [PW-1:0]   lohi, sum;

  always_ff @(posedge clk) begin
    if (en) begin
      aa   <= a[W-1] ? $unsigned(-a) : $unsigned(a);
      bb   <= b[W-1] ? $unsigned(-b) : $unsigned(b);
      n1   <= a[W-1] ^ b[W-1];
      p00  <= aa[H-1:0] * bb[H-1:0];
      p01  <= aa[H-1:0] * bb[W-1:H];
      p10  <= aa[W-1:H] * bb[H-1:0];
      p11  <= aa[W-1:H] * bb[W-1:H];
      n2   <= n1;
      mid  <= (2*H+1)'(p01) + (2*H+1)'(p10);
      lohi <= {p11, p00};
      n3   <= n2;
      sum  <= lohi + PW'({mid, {H{1'b0}}});
      n4   <= n3;
      p    <= n4 ? -$signed(sum) : $signed(sum);
    end
  end

endmodule

`default_nettype wire

// ===== design/cplu_mulna.sv =====
// cplu_mulna: magnitude and sign of a difference component times a numerator
// four 35-bit slices of the numerator; uses cplu_pkg
`default_nettype none

module cplu_mulna (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [cplu_pkg::DIFF_W-1:0]  a,
  input  wire logic signed [cplu_pkg::NUM_W-1:0]   b,
  output logic [cplu_pkg::MAG_W-1:0]               mag,
  output logic                                     neg
);

  localparam int AW = cplu_pkg::DIFF_W;
  localparam int BW = cplu_pkg::NUM_W;
  localparam int S  = 35;
  localparam int SW = 4 * S;
  localparam int PW = AW + S;

  logic [AW-1:0] am;
  logic [SW-1:0] bm;
  logic          n1, n2;
  logic [PW-1:0] pp [4];

  always_ff @(posedge clk) begin
    if (en) begin
      am <= a[AW-1] ? $unsigned(-a) : $unsigned(a);
      bm <= b[BW-1] ? SW'($unsigned(-b)) : SW'($unsigned(b));
      n1 <= a[AW-1] ^ b[BW-1];
      for (int j = 0; j < 4; j++) begin
        pp[j] <= am * bm[S*j +: S];
      end
      n2  <= n1;
      // even and odd slices do not overlap, so each pair is a concatenation
      mag <= cplu_pkg::MAG_W'({pp[2], {(2*S-PW){1'b0}}, pp[0]}
             + {pp[3], {(2*S-PW){1'b0}}, pp[1], {S{1'b0}}});
      neg <= n2;
    end
  end

endmodule

`default_nettype wire

// ===== design/cplu_div.sv =====
// cplu_div: pipelined restoring divider, one quotient bit per stage, with rounding
// flags quotients too wide for the quotient bits; uses cplu_pkg
`default_nettype none

module cplu_div (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [cplu_pkg::MAG_W-1:0]         num,
  input  wire logic                               num_neg,
  input  wire logic [cplu_pkg::NUM_W-1:0]         den,
  output logic [cplu_pkg::QUOT_W-1:0]             quot,
  output logic                                    quot_neg,
  output logic                                    quot_sat
);

  localparam int STEPS = cplu_pkg::QUOT_BITS;
  localparam int DW    = cplu_pkg::NUM_W;
  localparam int RW    = DW + STEPS;

  logic [RW-1:0]    r_s [STEPS+1];
  logic [DW-1:0]    d_s [STEPS+1];
  logic [STEPS-1:0] q_s [STEPS+1];
  logic             n_s [STEPS+1];
  logic             s_s [STEPS+1];
  logic             up;

  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0] <= RW'(num);
      d_s[0] <= den;
      q_s[0] <= '0;
      n_s[0] <= num_neg;
      s_s[0] <= RW'(num) >= {den, {STEPS{1'b0}}};
    end
  end

  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    localparam int K = STEPS - i;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(d_s[i-1]) << K;
    assign ge  = r_s[i-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i] <= ge ? r_s[i-1] - dsh : r_s[i-1];
        d_s[i] <= d_s[i-1];
        q_s[i] <= {q_s[i-1][STEPS-2:0], ge};
        n_s[i] <= n_s[i-1];
        s_s[i] <= s_s[i-1];
      end
    end
  end

  // round half away from zero on the magnitude
  assign up = {r_s[STEPS], 1'b0} >= (RW+1)'(d_s[STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      quot     <= {1'b0, q_s[STEPS]} + {{STEPS{1'b0}}, up};
      quot_neg <= n_s[STEPS];
      quot_sat <= s_s[STEPS];
    end
  end

endmodule

`default_nettype wire

// ===== design/closest_points_between_lines_unit.sv =====
// closest_points_between_lines_unit: top level of the shortest segment pipeline
// uses cplu_pkg, cplu_mul68, cplu_mulna, cplu_div
`default_nettype none

// Takes one pair of 3D lines per cycle while near is not stalled (start and
// end point each, Q16.16) and returns the closest point on each line,
// saturated to the coordinate range. Most of the pipeline depth lies in the
// dividers: each of the six quotients comes out of a restoring divider that
// resolves one bit per stage over 34 stages, plus a range check and a rounding
// stage. All math is exact integer arithmetic, so the fraction width has no
// effect on results. When the lines are parallel or either has zero length,
// degenerate is set and the two start points come back unchanged. A stall on
// near freezes the whole pipeline; pair_ready is low only while a finished
// word waits on near.
module closest_points_between_lines_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pair_valid,
  output logic                       pair_ready,
  input  wire cplu_pkg::pair_word_t  pair,
  output logic                       near_valid,
  input  wire logic                  near_ready,
  output cplu_pkg::near_word_t       near
);

  localparam int CW = cplu_pkg::COORD_W;
  localparam int XW = cplu_pkg::DIFF_W;
  localparam int SW = CW + 5;   // start plus signed quotient

  logic en;

  // input points as component arrays
  logic signed [CW-1:0] p1 [3], p2 [3], p3 [3], p4 [3];

  // stage one: difference vectors
  logic signed [XW-1:0] u_a [3], v_a [3], w_a [3];
  logic signed [CW-1:0] s1_a [3], s3_a [3];

  // stage two: component products
  logic signed [cplu_pkg::PROD_W-1:0] pr_wv [3], pr_uv [3], pr_wu [3], pr_vv [3], pr_uu [3];

  // stage three: dot products
  logic signed [cplu_pkg::DOT_W-1:0] d_wv, d_uv, d_wu, d_vv, d_uu;

  // products of dot products
  logic signed [cplu_pkg::MPROD_W-1:0] m_uuvv, m_uvuv, m_wvuv, m_wuvv, m_wvuu, m_uvwu;

  // den and the two numerators
  logic signed [cplu_pkg::NUM_W-1:0] den, na, nb;
  logic                              dz;

  // delay lines for side data
  logic signed [XW-1:0]              u_dl [cplu_pkg::DL_UV][3];
  logic signed [XW-1:0]              v_dl [cplu_pkg::DL_UV][3];
  logic [cplu_pkg::NUM_W-1:0]        den_dl [cplu_pkg::DL_DEN];
  logic                              dz_dl [cplu_pkg::DL_DEG];
  logic signed [CW-1:0]              s1_dl [cplu_pkg::DL_START][3];
  logic signed [CW-1:0]              s3_dl [cplu_pkg::DL_START][3];
  logic                              vld [cplu_pkg::PIPE_DEPTH];

  // quotient side
  logic [cplu_pkg::MAG_W-1:0]  mag1 [3], mag3 [3];
  logic                        mn1 [3], mn3 [3];
  logic [cplu_pkg::QUOT_W-1:0] q1 [3], q3 [3];
  logic                        qn1 [3], qn3 [3], qs1 [3], qs3 [3];

  logic signed [CW-1:0] r1 [3], r3 [3];
  logic                 deg_late;

  // start plus rounded quotient, clamped to the coordinate range
  function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] s,
                                                  input logic [cplu_pkg::QUOT_W-1:0] q,
                                                  input logic qn, input logic qs);
    logic signed [SW-1:0] qv;
    logic signed [SW-1:0] sum;
    logic signed [CW-1:0] lim;
    qv  = qn ? -$signed(SW'(q)) : $signed(SW'(q));
    sum = SW'(s) + qv;
    lim = qn ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    if (qs) begin
      return lim;
    end else if (sum[SW-1:CW-1] != {(SW-CW+1){sum[CW-1]}}) begin
      return sum[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      return sum[CW-1:0];
    end
  endfunction

  // whole pipeline moves unless a result word is stuck on the output
  assign en         = !near_valid || near_ready;
  assign pair_ready = en;

  always_comb begin
    p1[0] = pair.first_start_x;  p1[1] = pair.first_start_y;  p1[2] = pair.first_start_z;
    p2[0] = pair.first_end_x;    p2[1] = pair.first_end_y;    p2[2] = pair.first_end_z;
    p3[0] = pair.second_start_x; p3[1] = pair.second_start_y; p3[2] = pair.second_start_z;
    p4[0] = pair.second_end_x;   p4[1] = pair.second_end_y;   p4[2] = pair.second_end_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_a[k]  <= XW'(p2[k]) - XW'(p1[k]);
        v_a[k]  <= XW'(p4[k]) - XW'(p3[k]);
        w_a[k]  <= XW'(p1[k]) - XW'(p3[k]);
        s1_a[k] <= p1[k];
        s3_a[k] <= p3[k];
        pr_wv[k] <= w_a[k] * v_a[k];
        pr_uv[k] <= v_a[k] * u_a[k];
        pr_wu[k] <= w_a[k] * u_a[k];
        pr_vv[k] <= v_a[k] * v_a[k];
        pr_uu[k] <= u_a[k] * u_a[k];
      end
      d_wv <= pr_wv[0] + pr_wv[1] + pr_wv[2];
      d_uv <= pr_uv[0] + pr_uv[1] + pr_uv[2];
      d_wu <= pr_wu[0] + pr_wu[1] + pr_wu[2];
      d_vv <= pr_vv[0] + pr_vv[1] + pr_vv[2];
      d_uu <= pr_uu[0] + pr_uu[1] + pr_uu[2];
      // den is zero exactly when the two products agree
      den <= cplu_pkg::NUM_W'(m_uuvv) - cplu_pkg::NUM_W'(m_uvuv);
      na  <= cplu_pkg::NUM_W'(m_wvuv) - cplu_pkg::NUM_W'(m_wuvv);
      nb  <= cplu_pkg::NUM_W'(m_wvuu) - cplu_pkg::NUM_W'(m_uvwu);
      dz  <= m_uuvv == m_uvuv;
    end
  end

  cplu_mul68 u_m_uuvv (.clk(clk), .en(en), .a(d_uu), .b(d_vv), .p(m_uuvv));
  cplu_mul68 u_m_uvuv (.clk(clk), .en(en), .a(d_uv), .b(d_uv), .p(m_uvuv));
  cplu_mul68 u_m_wvuv (.clk(clk), .en(en), .a(d_wv), .b(d_uv), .p(m_wvuv));
  cplu_mul68 u_m_wuvv (.clk(clk), .en(en), .a(d_wu), .b(d_vv), .p(m_wuvv));
  cplu_mul68 u_m_wvuu (.clk(clk), .en(en), .a(d_wv), .b(d_uu), .p(m_wvuu));
  cplu_mul68 u_m_uvwu (.clk(clk), .en(en), .a(d_uv), .b(d_wu), .p(m_uvwu));

  // side data follows the arithmetic stage by stage
  always_ff @(posedge clk) begin
    if (en) begin
      u_dl[0]   <= u_a;
      v_dl[0]   <= v_a;
      s1_dl[0]  <= s1_a;
      s3_dl[0]  <= s3_a;
      den_dl[0] <= $unsigned(den);
      dz_dl[0]  <= dz;
      for (int i = 1; i < cplu_pkg::DL_UV; i++) begin
        u_dl[i] <= u_dl[i-1];
        v_dl[i] <= v_dl[i-1];
      end
      for (int i = 1; i < cplu_pkg::DL_DEN; i++) begin
        den_dl[i] <= den_dl[i-1];
      end
      for (int i = 1; i < cplu_pkg::DL_DEG; i++) begin
        dz_dl[i] <= dz_dl[i-1];
      end
      for (int i = 1; i < cplu_pkg::DL_START; i++) begin
        s1_dl[i] <= s1_dl[i-1];
        s3_dl[i] <= s3_dl[i-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    cplu_mulna u_mul1 (.clk(clk), .en(en), .a(u_dl[cplu_pkg::DL_UV-1][k]), .b(na),
                       .mag(mag1[k]), .neg(mn1[k]));
    cplu_mulna u_mul3 (.clk(clk), .en(en), .a(v_dl[cplu_pkg::DL_UV-1][k]), .b(nb),
                       .mag(mag3[k]), .neg(mn3[k]));
    cplu_div u_div1 (.clk(clk), .en(en), .num(mag1[k]), .num_neg(mn1[k]),
                     .den(den_dl[cplu_pkg::DL_DEN-1]),
                     .quot(q1[k]), .quot_neg(qn1[k]), .quot_sat(qs1[k]));
    cplu_div u_div3 (.clk(clk), .en(en), .num(mag3[k]), .num_neg(mn3[k]),
                     .den(den_dl[cplu_pkg::DL_DEN-1]),
                     .quot(q3[k]), .quot_neg(qn3[k]), .quot_sat(qs3[k]));
  end

  // final placement; a degenerate pair passes its start points through
  assign deg_late = dz_dl[cplu_pkg::DL_DEG-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r1[k] = deg_late ? s1_dl[cplu_pkg::DL_START-1][k]
                       : place(s1_dl[cplu_pkg::DL_START-1][k], q1[k], qn1[k], qs1[k]);
      r3[k] = deg_late ? s3_dl[cplu_pkg::DL_START-1][k]
                       : place(s3_dl[cplu_pkg::DL_START-1][k], q3[k], qn3[k], qs3[k]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      near.near_first_x  <= r1[0];
      near.near_first_y  <= r1[1];
      near.near_first_z  <= r1[2];
      near.near_second_x <= r3[0];
      near.near_second_y <= r3[1];
      near.near_second_z <= r3[2];
      near.degenerate    <= deg_late;
    end
  end

  // valid bits, one per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cplu_pkg::PIPE_DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
      near_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= pair_valid;
      for (int i = 1; i < cplu_pkg::PIPE_DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
      near_valid <= vld[cplu_pkg::PIPE_DEPTH-1];
    end
  end

endmodule

`default_nettype wire

// ===== design/cplu_checker.sv =====
// cplu_checker: port-level assertions for the closest points unit
// bound to closest_points_between_lines_unit; uses cplu_pkg
`default_nettype none

module cplu_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 pair_ready,
  input wire logic                 near_valid,
  input wire logic                 near_ready,
  input wire cplu_pkg::near_word_t near
);

  // a stalled result word holds
  a_near_hold: assert property (@(posedge clk) disable iff (rst)
    near_valid && !near_ready |=> near_valid && $stable(near))
    else $error("result word changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !near_valid)
    else $error("result word valid right after reset");

  // an empty output never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !near_valid |-> pair_ready)
    else $error("input blocked with no result waiting");

  // a taken result frees the input in the same cycle
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    near_valid && near_ready |-> pair_ready)
    else $error("input blocked while result is taken");

endmodule

bind closest_points_between_lines_unit cplu_checker u_cplu_checker (.*);

`default_nettype wire

// ===== tb/sv/closest_points_between_lines_unit_test.sv =====
// closest_points_between_lines_unit_test: self-checking bench for the closest points unit
// drives pair words, predicts near words with exact wide arithmetic; needs cplu_pkg and the dut
`timescale 1ns / 100ps

module closest_points_between_lines_unit_test;

  localparam int LATENCY   = 49;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 500;
  localparam int N_DIRECT  = 10;

  // wide enough for every product the math forms (u * na is under 380 bits)
  typedef logic signed [511:0] wide_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pair_valid = 1'b0;
  logic                 pair_ready;
  cplu_pkg::pair_word_t pair = '0;
  logic                 near_valid;
  logic                 near_ready = 1'b0;
  cplu_pkg::near_word_t near;

  closest_points_between_lines_unit dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
    .near_valid(near_valid), .near_ready(near_ready), .near(near)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cplu_pkg::near_word_t expected_near_q[$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         send_done = 1'b0;
  bit         long_holdoff = 1'b0;
  bit         holdoff_done = 1'b0;

  // round to nearest, ties away from zero; den is positive
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t mag, q, r;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q = q + 1;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [cplu_pkg::COORD_W-1:0] clamp_coord(wide_t x);
    wide_t hi, lo;
    hi = 2 ** (cplu_pkg::COORD_W - 1) - 1;
    lo = -(2 ** (cplu_pkg::COORD_W - 1));
    if (x > hi) return hi[cplu_pkg::COORD_W-1:0];
    if (x < lo) return lo[cplu_pkg::COORD_W-1:0];
    return x[cplu_pkg::COORD_W-1:0];
  endfunction

  function automatic cplu_pkg::near_word_t closest_points(cplu_pkg::pair_word_t p);
    cplu_pkg::near_word_t r;
    wide_t p1[3], p2[3], p3[3], p4[3], u[3], v[3], w[3];
    wide_t uu, vv, uv, wu, wv, den, na, nb;
    p1[0] = p.first_start_x;  p1[1] = p.first_start_y;  p1[2] = p.first_start_z;
    p2[0] = p.first_end_x;    p2[1] = p.first_end_y;    p2[2] = p.first_end_z;
    p3[0] = p.second_start_x; p3[1] = p.second_start_y; p3[2] = p.second_start_z;
    p4[0] = p.second_end_x;   p4[1] = p.second_end_y;   p4[2] = p.second_end_z;
    uu = 0; vv = 0; uv = 0; wu = 0; wv = 0;
    for (int k = 0; k < 3; k++) begin
      u[k] = p2[k] - p1[k];
      v[k] = p4[k] - p3[k];
      w[k] = p1[k] - p3[k];
      uu += u[k] * u[k];
      vv += v[k] * v[k];
      uv += u[k] * v[k];
      wu += w[k] * u[k];
      wv += w[k] * v[k];
    end
    den = uu * vv - uv * uv;
    na  = wv * uv - wu * vv;
    nb  = wv * uu - uv * wu;
    if (den == 0) begin
      r.near_first_x  = p.first_start_x;
      r.near_first_y  = p.first_start_y;
      r.near_first_z  = p.first_start_z;
      r.near_second_x = p.second_start_x;
      r.near_second_y = p.second_start_y;
      r.near_second_z = p.second_start_z;
      r.degenerate    = 1'b1;
    end else begin
      r.near_first_x  = clamp_coord(p1[0] + div_round(u[0] * na, den));
      r.near_first_y  = clamp_coord(p1[1] + div_round(u[1] * na, den));
      r.near_first_z  = clamp_coord(p1[2] + div_round(u[2] * na, den));
      r.near_second_x = clamp_coord(p3[0] + div_round(v[0] * nb, den));
      r.near_second_y = clamp_coord(p3[1] + div_round(v[1] * nb, den));
      r.near_second_z = clamp_coord(p3[2] + div_round(v[2] * nb, den));
      r.degenerate    = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [cplu_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2047)) - 1024;   // tiny values, within 1/64 of a unit
      2: return {16'($urandom_range(0, 255) - 128), 16'h0}; // whole units
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom & 32'h00ffffff) - 32'sh00800000;
    endcase
  endfunction

  function automatic cplu_pkg::pair_word_t rand_pair();
    cplu_pkg::pair_word_t p;
    logic [cplu_pkg::COORD_W-1:0] c[12];
    for (int k = 0; k < 12; k++) c[k] = rand_coord();
    case ($urandom_range(0, 9))
      0: for (int k = 0; k < 3; k++) c[3 + k] = c[k];              // first line a point
      1: for (int k = 0; k < 3; k++) c[9 + k] = c[6 + k];          // second line a point
      2: for (int k = 0; k < 3; k++) c[9 + k] = c[6 + k] + (c[3 + k] - c[k]); // parallel
      default: ;
    endcase
    p = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
    return p;
  endfunction

  // directed rows: degenerate rows carry a typed result, the rest use the predictor
  cplu_pkg::pair_word_t direct_pair[N_DIRECT];
  bit                   direct_typed[N_DIRECT];
  cplu_pkg::near_word_t direct_near[N_DIRECT];

  initial begin
    // all zero: both lines are points
    direct_pair[0] = '0;
    direct_typed[0] = 1'b1;
    direct_near[0] = '{0, 0, 0, 0, 0, 0, 1'b1};
    // extreme coordinates, both lines collapse to a point
    direct_pair[1] = {{6{32'h7fffffff}}, {6{32'h80000000}}};
    direct_typed[1] = 1'b1;
    direct_near[1] = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h80000000, 1'b1};
    // parallel lines along x
    direct_pair[2] = {32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
                      32'h0, 32'h10000, 32'h0, 32'h20000, 32'h10000, 32'h0};
    direct_typed[2] = 1'b1;
    direct_near[2] = '{0, 0, 0, 0, 32'h10000, 0, 1'b1};
    // x axis against a crossing line offset in z
    direct_pair[3] = {32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
                      32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h10000};
    direct_typed[3] = 1'b0;
    // full range line against a tiny one: far points saturate
    direct_pair[4] = {32'h80000000, 32'h80000000, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h0,
                      32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1};
    direct_typed[4] = 1'b0;
    direct_pair[5] = {32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7ffffffe, 32'h80000000};
    direct_typed[5] = 1'b0;
    direct_pair[6] = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h80000000, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0, 32'h1};
    direct_typed[6] = 1'b0;
    // second line degenerate only
    direct_pair[7] = {32'h1, 32'h2, 32'h3, 32'h40000, 32'h5, 32'h6,
                      32'hffff0000, 32'h8, 32'h9, 32'hffff0000, 32'h8, 32'h9};
    direct_typed[7] = 1'b1;
    direct_near[7] = '{32'h1, 32'h2, 32'h3, 32'hffff0000, 32'h8, 32'h9, 1'b1};
    direct_pair[8] = {12{32'hffffffff}};
    direct_typed[8] = 1'b1;
    direct_near[8] = '{32'hffffffff, 32'hffffffff, 32'hffffffff,
                       32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1};
    // skew lines with rounding ties possible
    direct_pair[9] = {32'h1, 32'h0, 32'h0, 32'h3, 32'h1, 32'h0,
                      32'h0, 32'h0, 32'h1, 32'h1, 32'h2, 32'h3};
    direct_typed[9] = 1'b0;
  end

  // called at a falling edge; valid stays high across words when there is no gap
  task automatic offer_pair(cplu_pkg::pair_word_t p, bit typed, cplu_pkg::near_word_t t);
    int gap;
    gap = long_holdoff ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;   // back to back stretches
    if (gap > 0) begin
      pair_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pair_valid <= 1'b1;
    pair <= p;
    @(posedge clk);
    while (!pair_ready) @(posedge clk);
    // accepted at this edge
    expected_near_q.push_back(typed ? t : closest_points(p));
    @(negedge clk);
  endtask

  // sender
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECT; i++) offer_pair(direct_pair[i], direct_typed[i], direct_near[i]);
    for (int i = 0; i < N_RANDOM; i++) offer_pair(rand_pair(), 1'b0, '0);
    pair_valid <= 1'b0;
    send_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off so the pipeline fills up
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!holdoff_done && expected_near_q.size() >= 4) begin
        long_holdoff = 1'b1;
        near_ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_holdoff = 1'b0;
        holdoff_done = 1'b1;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        near_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      near_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // checker: sample at the rising edge
  always @(posedge clk) begin
    if (!rst && near_valid && near_ready) begin
      if (expected_near_q.size() == 0) begin
        $display("%0t: unexpected near word %h", $time, near);
        error_count++;
      end else begin
        cplu_pkg::near_word_t e;
        e = expected_near_q.pop_front();
        if (near !== e) begin
          $display("%0t: near mismatch expected %h actual %h", $time, e, near);
          error_count++;
        end
      end
    end
  end

  // end of run and watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
        $display("TB_ERROR");
        $finish;
      end
      if (send_done && expected_near_q.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0) begin
          $display("TB_OK");
        end else begin
          $display("TB_ERROR");
        end
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
design/cplu_pkg.sv
design/cplu_mul68.sv
design/cplu_mulna.sv
design/cplu_div.sv
design/closest_points_between_lines_unit.sv
design/cplu_checker.sv
tb/sv/closest_points_between_lines_unit_test.sv
